/* hw/rtl/utt_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utt_pkg;

  localparam int unsigned CAP_W           = 24;
  localparam int unsigned UNIT_W          = 16;
  localparam int unsigned CP_W            = 21;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 24'hFF_FFFF;
  localparam logic [UNIT_W-1:0] UNIT_REPLACE = 16'h003F;
  localparam logic [5:0]        HI_SURR_TAG  = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]        LO_SURR_TAG  = 6'b110111;  // 0xDC00 >> 10
  localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h01_0000;
  localparam logic [CP_W-1:0]   CP_MAX       = 21'h10_FFFF;

  // Work for one input item, handed from the decoder to the result sequencer.
  typedef struct packed {
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic [1:0]        n_units;   // code units to emit: 0, 1 or 2
    logic              summary;   // a summary follows the units
    logic [CAP_W-1:0]  count;
    logic              err;
  } entry_t;

endpackage

/* hw/rtl/utt_front.sv */
// Decoder front end: tracks stream state, builds an entry per byte that has results.
module utt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [utt_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          in_push,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_stream,
  input  logic                          q_full,
  output logic                          q_push,
  output utt_pkg::entry_t               q_entry
);
  import utt_pkg::*;

  logic [CAP_W-1:0]  cap_r;
  logic [1:0]        pend_r, pend_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic              stop_r, stop_nxt;
  logic [CAP_W-1:0]  uw_r, uw_nxt;

  logic              accept;
  logic [CP_W-1:0]   acc_sh;
  logic [CP_W-1:0]   cp;
  logic [CP_W-1:0]   cp_off;
  logic              emit_cp;
  logic              err_hit;
  logic [1:0]        want;
  logic [UNIT_W-1:0] u0, u1;
  logic              w0, w1;
  logic [CAP_W:0]    uw_plus1;
  logic [1:0]        n_wr;

  assign accept = in_push && !q_full;
  assign acc_sh = {acc_r[CP_W-7:0], in_data_byte[5:0]};
  assign cp_off = cp - CP_SUPP_BASE;

  // Byte decode and code point to UTF-16 conversion.
  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    stop_nxt = stop_r;
    cp       = '0;
    emit_cp  = 1'b0;
    err_hit  = 1'b0;
    want     = 2'd0;
    u0       = '0;
    u1       = '0;
    if (!stop_r) begin
      if (pend_r == 2'd0) begin
        if (!in_data_byte[7]) begin
          cp      = {{(CP_W-8){1'b0}}, in_data_byte};
          emit_cp = 1'b1;
        end else if (in_data_byte[7:5] == 3'b110) begin
          pend_nxt = 2'd1;
          acc_nxt  = {{(CP_W-5){1'b0}}, in_data_byte[4:0]};
        end else if (in_data_byte[7:4] == 4'b1110) begin
          pend_nxt = 2'd2;
          acc_nxt  = {{(CP_W-4){1'b0}}, in_data_byte[3:0]};
        end else if (in_data_byte[7:3] == 5'b11110) begin
          pend_nxt = 2'd3;
          acc_nxt  = {{(CP_W-3){1'b0}}, in_data_byte[2:0]};
        end else begin
          err_hit = 1'b1;
        end
      end else if (in_data_byte[7:6] == 2'b10) begin
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          cp      = acc_sh;
          acc_nxt = '0;
          emit_cp = 1'b1;
        end else begin
          acc_nxt = acc_sh;
        end
      end else begin
        err_hit = 1'b1;
      end
    end

    if (emit_cp) begin
      if (cp[CP_W-1:UNIT_W] == '0) begin
        want = 2'd1;
        u0   = cp[UNIT_W-1:0];
      end else if (cp <= CP_MAX) begin
        want = 2'd2;
        u0   = {HI_SURR_TAG, cp_off[19:10]};
        u1   = {LO_SURR_TAG, cp_off[9:0]};
      end else begin
        err_hit = 1'b1;
      end
    end

    // A sequence cut off by the end of the stream is an error as well.
    if (in_end_of_stream && !stop_r && !err_hit && pend_nxt != 2'd0) begin
      err_hit = 1'b1;
    end

    if (err_hit) begin
      want     = 2'd1;
      u0       = UNIT_REPLACE;
      u1       = '0;
      stop_nxt = 1'b1;
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
  end

  // Capacity check: a unit is written only while the count is below capacity.
  always_comb begin
    uw_plus1 = {1'b0, uw_r} + {{CAP_W{1'b0}}, 1'b1};
    w0       = (want != 2'd0) && (uw_r < cap_r);
    w1       = (want == 2'd2) && (uw_plus1 < {1'b0, cap_r});
    n_wr     = {1'b0, w0} + {1'b0, w1};
    uw_nxt   = uw_r + {{(CAP_W-2){1'b0}}, n_wr};
  end

  // Entry for the queue.
  always_comb begin
    q_entry.unit0   = u0;
    q_entry.unit1   = u1;
    q_entry.n_units = n_wr;
    q_entry.summary = in_end_of_stream;
    q_entry.count   = uw_nxt;
    q_entry.err     = stop_nxt;
    q_push          = accept && ((n_wr != 2'd0) || in_end_of_stream);
  end

  // Stream state and capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      pend_r <= 2'd0;
      acc_r  <= '0;
      stop_r <= 1'b0;
      uw_r   <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        if (in_end_of_stream) begin
          pend_r <= 2'd0;
          acc_r  <= '0;
          stop_r <= 1'b0;
          uw_r   <= '0;
        end else begin
          pend_r <= pend_nxt;
          acc_r  <= acc_nxt;
          stop_r <= stop_nxt;
          uw_r   <= uw_nxt;
        end
      end
    end
  end

endmodule

/* hw/rtl/utt_queue.sv */
// Short queue of decoded entries between the decoder and the result sequencer.
module utt_queue #(
  parameter int unsigned DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utt_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output utt_pkg::entry_t head
);
  import utt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/utt_back.sv */
// Result sequencer: walks the head entry and presents its results one at a time.
module utt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  utt_pkg::entry_t               q_head,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [utt_pkg::UNIT_W-1:0]    out_code_unit,
  output logic                          out_is_summary,
  output logic [utt_pkg::CAP_W-1:0]     out_unit_count,
  output logic                          out_ended_by_error,
  output logic                          out_last_of_run
);
  import utt_pkg::*;

  logic [1:0] k_r;
  logic [1:0] n_res;
  logic       is_unit;
  logic       last;
  logic       take;

  // Result k of the head entry: units first, then the summary.
  always_comb begin
    n_res   = q_head.n_units + {1'b0, q_head.summary};
    is_unit = (k_r < q_head.n_units);
    last    = (k_r == n_res - 2'd1);
    take    = out_pop && !q_empty;

    out_empty          = q_empty;
    out_is_summary     = !is_unit;
    out_code_unit      = !is_unit ? '0 : ((k_r == 2'd0) ? q_head.unit0 : q_head.unit1);
    out_unit_count     = is_unit ? '0 : q_head.count;
    out_ended_by_error = !is_unit && q_head.err;
    out_last_of_run    = last;
    q_pop              = take && last;
  end

  // Position within the head entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 2'd0;
    end else if (take) begin
      k_r <= last ? 2'd0 : k_r + 2'd1;
    end
  end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// An accepted byte's entry is registered in the entry queue; results come from its head.
// One byte per cycle in while in_full is low; results leave one per cycle while out_pop
// is high and a result is waiting, and the entry queue absorbs bursts.
// Reset (rst_n low, synchronous) empties the queue, clears the stream state and
// sets the capacity register to 0xFFFFFF.
module utf8_to_utf16_transcoder #(
  parameter int unsigned QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [utt_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_stream,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [utt_pkg::UNIT_W-1:0]    out_code_unit,
  output logic                          out_is_summary,
  output logic [utt_pkg::CAP_W-1:0]     out_unit_count,
  output logic                          out_ended_by_error,
  output logic                          out_last_of_run
);
  import utt_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_entry, q_head;

  assign in_full = q_full;

  // Decoder front end.
  utt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  // Entry queue.
  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Result sequencer.
  utt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_code_unit      (out_code_unit),
    .out_is_summary     (out_is_summary),
    .out_unit_count     (out_unit_count),
    .out_ended_by_error (out_ended_by_error),
    .out_last_of_run    (out_last_of_run)
  );

  // The decoder never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("entry pushed into a full queue");

  // A summary closes the results of its item and carries no code unit.
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_summary) |-> (out_last_of_run && out_code_unit == '0))
    else $error("summary result is not last or carries a code unit");

  // Unit results carry no count and no error flag.
  a_unit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_summary) |-> (out_unit_count == '0 && !out_ended_by_error))
    else $error("unit result carries summary fields");

  // A popped result that is not last leaves the queue holding its item.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_of_run) |=> !out_empty)
    else $error("item ended before its last result");

endmodule

/* test/utf16_result_checker.sv */
// Checker for the UTF-8 to UTF-16 transcoder: predicts every result and compares it.
`timescale 1ns / 100ps

module utf16_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [utt_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_of_stream,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic [utt_pkg::UNIT_W-1:0] out_code_unit,
  input  logic                       out_is_summary,
  input  logic [utt_pkg::CAP_W-1:0]  out_unit_count,
  input  logic                       out_ended_by_error,
  input  logic                       out_last_of_run,
  output int                         fail_count,
  output int                         results_outstanding
);

  localparam logic [23:0] CAPACITY_AT_RESET = 24'hFF_FFFF;
  localparam logic [15:0] REPLACEMENT_UNIT  = 16'h003F;
  localparam logic [20:0] SUPP_BASE         = 21'h01_0000;
  localparam logic [20:0] CODE_POINT_LIMIT  = 21'h10_FFFF;
  localparam logic [5:0]  HIGH_SURROGATE    = 6'b110110;
  localparam logic [5:0]  LOW_SURROGATE     = 6'b110111;
  localparam logic [2:0]  LEAD2_TAG         = 3'b110;
  localparam logic [3:0]  LEAD3_TAG         = 4'b1110;
  localparam logic [4:0]  LEAD4_TAG         = 5'b11110;
  localparam logic [1:0]  CONT_TAG          = 2'b10;
  localparam int          MAX_REPORTS       = 10;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_summary;
    logic [23:0] unit_count;
    logic        ended_by_error;
    logic        last_of_run;
  } utf16_result_t;

  // Results still owed by the block, oldest first.
  utf16_result_t results_due[$];
  // Results caused by the item being decoded right now.
  utf16_result_t step_results[3];
  int            step_count;

  // Predicted decoder state.
  logic [23:0] unit_cap;
  logic [23:0] stream_units;
  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  logic        halted;
  int          mismatches = 0;

  // A unit is only produced while the stream is below its capacity.
  task automatic write_unit(input logic [15:0] unit);
    utf16_result_t r;
    if (stream_units < unit_cap) begin
      r = '0;
      r.code_unit = unit;
      step_results[step_count] = r;
      step_count++;
      stream_units = stream_units + 24'd1;
    end
  endtask

  // A decode error writes the replacement unit and mutes the rest of the stream.
  task automatic flag_error();
    write_unit(REPLACEMENT_UNIT);
    halted = 1'b1;
    cont_left = 2'd0;
    cp_acc = '0;
  endtask

  // Emit one code point as a single unit or a surrogate pair.
  task automatic emit_code_point(input logic [20:0] cp);
    logic [20:0] offset;
    if (cp < SUPP_BASE) begin
      write_unit(cp[15:0]);
    end else if (cp <= CODE_POINT_LIMIT) begin
      offset = cp - SUPP_BASE;
      write_unit({HIGH_SURROGATE, offset[19:10]});
      write_unit({LOW_SURROGATE, offset[9:0]});
    end else begin
      flag_error();
    end
  endtask

  // Decode one accepted byte and queue the results it causes.
  task automatic transcode_byte(input logic [7:0] b, input logic eos);
    utf16_result_t summ;
    logic [20:0]   cp;
    step_count = 0;
    if (!halted) begin
      if (cont_left == 2'd0) begin
        if (!b[7]) begin
          emit_code_point({13'd0, b});
        end else if (b[7:5] == LEAD2_TAG) begin
          cont_left = 2'd1;
          cp_acc = {16'd0, b[4:0]};
        end else if (b[7:4] == LEAD3_TAG) begin
          cont_left = 2'd2;
          cp_acc = {17'd0, b[3:0]};
        end else if (b[7:3] == LEAD4_TAG) begin
          cont_left = 2'd3;
          cp_acc = {18'd0, b[2:0]};
        end else begin
          flag_error();
        end
      end else if (b[7:6] == CONT_TAG) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          cp = cp_acc;
          cp_acc = '0;
          emit_code_point(cp);
        end
      end else begin
        flag_error();
      end
    end

    // End of stream: a cut-off sequence is an error, then the summary closes the stream.
    if (eos) begin
      if (!halted && cont_left != 2'd0) flag_error();
      summ = '0;
      summ.is_summary = 1'b1;
      summ.unit_count = stream_units;
      summ.ended_by_error = halted;
      step_results[step_count] = summ;
      step_count++;
      cont_left = 2'd0;
      cp_acc = '0;
      halted = 1'b0;
      stream_units = '0;
    end

    if (step_count > 0) step_results[step_count-1].last_of_run = 1'b1;
    for (int i = 0; i < step_count; i++) results_due.push_back(step_results[i]);
  endtask

  // Compare one popped result with the oldest expectation.
  task automatic check_result(input utf16_result_t got);
    utf16_result_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result with nothing expected: unit=%h summary=%b count=%0d error=%b last=%b",
                 $time, got.code_unit, got.is_summary, got.unit_count, got.ended_by_error,
                 got.last_of_run);
    end else begin
      want = results_due.pop_front();
      if (got.code_unit !== want.code_unit || got.is_summary !== want.is_summary ||
          got.unit_count !== want.unit_count || got.ended_by_error !== want.ended_by_error ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result mismatch: expected unit=%h summary=%b count=%0d error=%b last=%b,",
                   $time, want.code_unit, want.is_summary, want.unit_count, want.ended_by_error,
                   want.last_of_run,
                   " got unit=%h summary=%b count=%0d error=%b last=%b",
                   got.code_unit, got.is_summary, got.unit_count,
                   got.ended_by_error, got.last_of_run);
      end
    end
  endtask

  // Watch both channels and the configuration port at every edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      unit_cap = CAPACITY_AT_RESET;
      stream_units = '0;
      cont_left = 2'd0;
      cp_acc = '0;
      halted = 1'b0;
      results_due.delete();
    end else begin
      if (!out_empty && out_pop)
        check_result({out_code_unit, out_is_summary, out_unit_count, out_ended_by_error,
                      out_last_of_run});
      if (cfg_we) unit_cap = cfg_data;
      if (in_push && !in_full) transcode_byte(in_data_byte, in_end_of_stream);
    end
    fail_count <= mismatches;
    results_outstanding <= results_due.size();
  end

endmodule

/* test/utf8_to_utf16_transcoder_test.sv */
// Top of the transcoder testbench: clock, reset, byte streams, capacity phases and verdict.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 27;
  localparam int PHASE_ITEMS   = 30;
  localparam int NUM_PHASES    = 6;
  localparam int STEADY_PHASE  = 4;
  localparam int PRESSURE_ITEM = 100;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [utt_pkg::CAP_W-1:0]  cfg_data = '0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [7:0]                 in_data_byte = '0;
  logic                       in_end_of_stream = 1'b0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [utt_pkg::UNIT_W-1:0] out_code_unit;
  logic                       out_is_summary;
  logic [utt_pkg::CAP_W-1:0]  out_unit_count;
  logic                       out_ended_by_error;
  logic                       out_last_of_run;

  int   fail_count;
  int   results_outstanding;
  int   items_sent = 0;
  int   cycle_count = 0;
  // When set, neither side idles.
  logic steady = 1'b0;
  logic [7:0] stream_bytes[$];

  always #1 clk = ~clk;

  utf8_to_utf16_transcoder u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .in_end_of_stream   (in_end_of_stream),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_code_unit      (out_code_unit),
    .out_is_summary     (out_is_summary),
    .out_unit_count     (out_unit_count),
    .out_ended_by_error (out_ended_by_error),
    .out_last_of_run    (out_last_of_run)
  );

  utf16_result_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_data_byte        (in_data_byte),
    .in_end_of_stream    (in_end_of_stream),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_code_unit       (out_code_unit),
    .out_is_summary      (out_is_summary),
    .out_unit_count      (out_unit_count),
    .out_ended_by_error  (out_ended_by_error),
    .out_last_of_run     (out_last_of_run),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  // The result side stalls at random unless the steady stretch is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stop sending and wait until every expected result has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item and hold it until accepted, then maybe idle for a while.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_push <= 1'b1;
    in_data_byte <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    if (items_sent == PRESSURE_ITEM) begin
      drain();
    end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  // Capacity changes only while the block has nothing in flight.
  task automatic set_capacity(input logic [23:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [20:0] random_code_point(input int len);
    case (len)
      1:       return 21'($urandom_range(0, 21'h7F));
      2:       return 21'($urandom_range(0, 21'h7FF));
      3:       return 21'($urandom_range(0, 21'hFFFF));
      default: return 21'($urandom_range(21'h1_0000, 21'h10_FFFF));
    endcase
  endfunction

  // Append the UTF-8 encoding of a code point in the given number of bytes.
  task automatic append_code_point(input logic [20:0] cp, input int len);
    case (len)
      1: begin
        stream_bytes.push_back({1'b0, cp[6:0]});
      end
      2: begin
        stream_bytes.push_back({LEAD2_TAG, cp[10:6]});
        stream_bytes.push_back({CONT_TAG, cp[5:0]});
      end
      3: begin
        stream_bytes.push_back({LEAD3_TAG, cp[15:12]});
        stream_bytes.push_back({CONT_TAG, cp[11:6]});
        stream_bytes.push_back({CONT_TAG, cp[5:0]});
      end
      default: begin
        stream_bytes.push_back({LEAD4_TAG, cp[20:18]});
        stream_bytes.push_back({CONT_TAG, cp[17:12]});
        stream_bytes.push_back({CONT_TAG, cp[11:6]});
        stream_bytes.push_back({CONT_TAG, cp[5:0]});
      end
    endcase
  endtask

  // Mostly well-formed characters, with a few oversized, bad, truncated or noise ones.
  task automatic send_stream();
    int          chars;
    int          pick;
    int          len;
    int          keep;
    logic [20:0] cp;
    stream_bytes.delete();
    chars = $urandom_range(1, 6);
    repeat (chars) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        len = $urandom_range(1, 4);
        append_code_point(random_code_point(len), len);
      end else if (pick < 91) begin
        cp = 21'($urandom_range(21'h11_0000, 21'h1F_FFFF));
        append_code_point(cp, 4);
      end else if (pick < 94) begin
        if ($urandom_range(1) == 1) stream_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else stream_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (pick < 97) begin
        // Truncated sequence: the next character or the stream end cuts it off.
        len = $urandom_range(2, 4);
        append_code_point(random_code_point(len), len);
        keep = $urandom_range(1, len - 1);
        repeat (len - keep) void'(stream_bytes.pop_back());
      end else begin
        stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  initial begin
    logic [23:0] cap;
    int          start;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed streams at the reset capacity: range ends and surrogate pair.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // Code point above the limit, then a byte that must be ignored.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h41, 1'b1);
    // Continuation byte and invalid byte in lead position.
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Missing continuation byte.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    // Sequence cut off by the end of the stream.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);
    send_byte(8'h41, 1'b1);

    // Random streams under a series of capacities, zero and full scale among them.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       cap = 24'd0;
        1:       cap = 24'd1;
        2:       cap = 24'($urandom_range(2, 6));
        3:       cap = 24'($urandom_range(7, 24'hFF_FFFE));
        4:       cap = 24'hFF_FFFF;
        default: cap = 24'($urandom_range(2, 4));
      endcase
      set_capacity(cap);
      steady <= (phase == STEADY_PHASE);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_stream();
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
